FILE: src/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared constants for the minimum spanning tree block.
// ----------------------------------------------------------------------------
`default_nettype none
package kmst_pkg;
	localparam int MAX_VERTICES_DEF = 32;
	localparam int MAX_EDGES_DEF    = 496;
	localparam int IDX_W            = 6;   // row, col and vertex_count port width
	localparam int WGT_W            = 16;
	localparam int TOT_W            = 21;
	// edge key: biased weight, row, column; ascending key = sort order
	localparam int KEY_W            = WGT_W + 2 * IDX_W;
	localparam int VERTEX_COUNT_RST = 32;
endpackage
`default_nettype wire

FILE: src/kmst_ram.sv
// ----------------------------------------------------------------------------
// kmst_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module kmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: src/kruskal_minimum_spanning_tree.sv
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree
// Loads adjacency-matrix entries, then builds a minimum spanning tree.
// ----------------------------------------------------------------------------
// Matrix entries are taken one per cycle while busy is low; an entry with
// 0 < row < col <= MAX_VERTICES and nonzero weight goes to the edge memory
// if it has room. The entry with last set starts the run and busy stays high
// until all results are out. The run repeats a scan of the edge memory (one
// read per cycle) that picks the smallest in-range edge key above the previous
// pick, then walks the union-find parent memory for both ends and joins them.
// Tree edges then come from the tree memory, each read before it is sent; a
// graph that does not span, or has one vertex, gives one result, edge_valid low.
// result_valid marks each result for one cycle and the receiver cannot stall.
// vertex_count may be written at any time; the value at the last entry is used.
`default_nettype none
module kruskal_minimum_spanning_tree
	import kmst_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_data,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [IDX_W-1:0]  row,
	input  wire logic [IDX_W-1:0]  col,
	input  wire logic signed [WGT_W-1:0] weight,
	input  wire logic              last,
	output logic                   result_valid,
	output logic [IDX_W-1:0]       edge_u,
	output logic [IDX_W-1:0]       edge_v,
	output logic                   edge_valid,
	output logic signed [TOT_W-1:0] total_weight,
	output logic                   spanning,
	output logic                   last_result
);
	localparam int ET = $clog2(MAX_EDGES + 1);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int PA = $clog2(MAX_VERTICES);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_FINDU  = 3'd2;
	localparam logic [2:0] S_FINDV  = 3'd3;
	localparam logic [2:0] S_UNION  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     vcount_q;
	logic [VW-1:0]        n_q;
	logic [ET-1:0]        etotal_q;
	logic [ET-1:0]        scan_q;
	logic                 rd_s1;
	logic [KEY_W-1:0]     prev_q;
	logic                 have_prev_q;
	logic [KEY_W-1:0]     best_q;
	logic                 best_ok_q;
	logic [VW-1:0]        x_q;
	logic [VW-1:0]        ru_q;
	logic                 wait_q;
	logic [VW-1:0]        tcount_q;
	logic [MAX_VERTICES-1:0] pvalid_q;
	logic signed [TOT_W-1:0] total_q;
	logic [VW-1:0]        emit_q;
	logic                 emit_ph_q;

	// edge memory
	logic              e_we;
	logic [KEY_W-1:0]  e_rdata;
	logic [VW-1:0]     n_eff;
	logic              keep;

	// parent and tree memories
	logic              p_we;
	logic [VW-1:0]     p_rdata;
	logic              t_we;
	logic [2*IDX_W-1:0] t_rdata;

	logic [IDX_W-1:0]  best_row;
	logic [IDX_W-1:0]  best_col;
	logic [WGT_W-1:0]  best_w;
	logic [IDX_W-1:0]  cand_col;
	logic              cand;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		if (vcount_q == '0) begin
			n_eff = VW'(1);
		end else if (32'(vcount_q) > MAX_VERTICES) begin
			n_eff = VW'(MAX_VERTICES);
		end else begin
			n_eff = VW'(vcount_q);
		end
	end

	assign keep = (row != '0) && (row < col) && (32'(col) <= MAX_VERTICES) &&
		(weight != '0) && (etotal_q < ET'(MAX_EDGES));
	assign e_we = start && !busy && keep;

	assign best_row = best_q[2*IDX_W-1:IDX_W];
	assign best_col = best_q[IDX_W-1:0];
	assign best_w   = best_q[KEY_W-1:2*IDX_W] ^ {1'b1, {(WGT_W-1){1'b0}}};

	assign cand_col = e_rdata[IDX_W-1:0];
	assign cand = rd_s1 && (!have_prev_q || e_rdata > prev_q) &&
		(32'(cand_col) <= 32'(n_q)) && (!best_ok_q || e_rdata < best_q);

	assign p_we = (state_q == S_UNION) && (ru_q != x_q);
	assign t_we = p_we;

	kmst_ram #(.WIDTH(KEY_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (EA'(etotal_q)),
		.wdata ({weight ^ {1'b1, {(WGT_W-1){1'b0}}}, row, col}),
		.raddr (EA'(scan_q)),
		.rdata (e_rdata)
	);

	kmst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_parent_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (PA'(x_q - 1'b1)),
		.wdata (ru_q),
		.raddr (PA'(x_q - 1'b1)),
		.rdata (p_rdata)
	);

	kmst_ram #(.WIDTH(2*IDX_W), .DEPTH(MAX_VERTICES)) u_tree_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (PA'(tcount_q)),
		.wdata ({best_row, best_col}),
		.raddr (PA'(emit_q)),
		.rdata (t_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= IDX_W'(VERTEX_COUNT_RST);
		end else if (wr_en) begin
			vcount_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			etotal_q     <= '0;
			tcount_q     <= '0;
			pvalid_q     <= '0;
			have_prev_q  <= 1'b0;
			best_ok_q    <= 1'b0;
			rd_s1        <= 1'b0;
			wait_q       <= 1'b0;
			emit_ph_q    <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (keep) begin
							etotal_q <= etotal_q + 1'b1;
						end
						if (last) begin
							n_q         <= n_eff;
							have_prev_q <= 1'b0;
							best_ok_q   <= 1'b0;
							scan_q      <= '0;
							rd_s1       <= 1'b0;
							total_q     <= '0;
							state_q     <= (n_eff == VW'(1)) ? S_FINISH : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// one edge read per cycle, compare on the registered data
					if (scan_q < etotal_q) begin
						scan_q <= scan_q + 1'b1;
						rd_s1  <= 1'b1;
					end else begin
						rd_s1  <= 1'b0;
					end
					if (cand) begin
						best_q    <= e_rdata;
						best_ok_q <= 1'b1;
					end
					if (scan_q == etotal_q && !rd_s1) begin
						if (best_ok_q) begin
							x_q     <= VW'(best_row);
							wait_q  <= 1'b0;
							state_q <= S_FINDU;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINDU, S_FINDV: begin
					// walk parent pointers; a vertex with no stored parent is a root
					if (wait_q) begin
						x_q    <= p_rdata;
						wait_q <= 1'b0;
					end else if (!pvalid_q[PA'(x_q - 1'b1)]) begin
						if (state_q == S_FINDU) begin
							ru_q    <= x_q;
							x_q     <= VW'(best_col);
							state_q <= S_FINDV;
						end else begin
							state_q <= S_UNION;
						end
					end else begin
						wait_q <= 1'b1;
					end
				end
				S_UNION: begin
					if (ru_q != x_q) begin
						pvalid_q[PA'(x_q - 1'b1)] <= 1'b1;
						tcount_q <= tcount_q + 1'b1;
						total_q  <= total_q + TOT_W'(signed'(best_w));
					end
					if (ru_q != x_q && tcount_q + 1'b1 == n_q - 1'b1) begin
						state_q <= S_FINISH;
					end else begin
						prev_q      <= best_q;
						have_prev_q <= 1'b1;
						best_ok_q   <= 1'b0;
						scan_q      <= '0;
						rd_s1       <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_FINISH: begin
					if (tcount_q != n_q - 1'b1 || tcount_q == '0) begin
						result_valid <= 1'b1;
						edge_u       <= '0;
						edge_v       <= '0;
						edge_valid   <= 1'b0;
						total_weight <= '0;
						spanning     <= (tcount_q == n_q - 1'b1);
						last_result  <= 1'b1;
						etotal_q     <= '0;
						tcount_q     <= '0;
						pvalid_q     <= '0;
						state_q      <= S_IDLE;
					end else begin
						emit_q    <= '0;
						emit_ph_q <= 1'b0;
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					// read a tree edge, then register the read data onto the result outputs
					emit_ph_q <= !emit_ph_q;
					if (emit_ph_q) begin
						result_valid <= 1'b1;
						edge_u       <= t_rdata[2*IDX_W-1:IDX_W];
						edge_v       <= t_rdata[IDX_W-1:0];
						edge_valid   <= 1'b1;
						total_weight <= total_q;
						spanning     <= 1'b1;
						last_result  <= (emit_q + 1'b1 == tcount_q);
						emit_q       <= emit_q + 1'b1;
						if (emit_q + 1'b1 == tcount_q) begin
							etotal_q <= '0;
							tcount_q <= '0;
							pvalid_q <= '0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_tree_matches_sets: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(pvalid_q) == 32'(tcount_q))
		else $error("joined vertex count differs from tree edge count");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(state_q) == S_FINISH || $past(state_q) == S_EMIT))
		else $error("result outside finish or emit");

	a_plain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last) |=> !busy)
		else $error("non-final entry left block busy");

	a_union_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UNION && ru_q != x_q) |-> (tcount_q < n_q - 1'b1))
		else $error("tree grew past vertex count");
endmodule
`default_nettype wire

FILE: test/kruskal_minimum_spanning_tree_test.sv
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_test
// Self-checking bench for the minimum spanning tree block.
// ----------------------------------------------------------------------------
// Matrix entries are sent through the start/busy handshake. A scoreboard keeps
// its own edge list, sorts it and runs union-find on each final entry, then
// checks every strobed result in order. Directed runs cover disconnected,
// single-vertex and skipped-column cases; random graphs follow.
`timescale 1ns / 1ps
`default_nettype none
module kruskal_minimum_spanning_tree_test;
	import kmst_pkg::*;

	localparam int STALL_LIMIT = 40000;
	localparam int MAX_V       = MAX_VERTICES_DEF;
	localparam int MAX_E       = MAX_EDGES_DEF;

	typedef struct packed {
		logic [IDX_W-1:0]        u;
		logic [IDX_W-1:0]        v;
		logic                    valid;
		logic signed [TOT_W-1:0] total;
		logic                    span;
		logic                    lastr;
	} tree_result_t;

	class mst_scoreboard;
		logic [KEY_W-1:0] edge_keys[$];
		tree_result_t     tree_q[$];
		logic [IDX_W-1:0] vertex_count = VERTEX_COUNT_RST;
		int               errors = 0;
		int               runs = 0;
		int               checked = 0;

		function void note_entry(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
		                         logic signed [WGT_W-1:0] w, logic l);
			int               n;
			int               parent[MAX_V+1];
			int               ru, rv, steps, total;
			logic [KEY_W-1:0] picked[$];
			logic [KEY_W-1:0] k;
			tree_result_t     res;
			if (r >= 1 && r < c && c <= MAX_V && w != 0 && edge_keys.size() < MAX_E)
				edge_keys.push_back({~w[WGT_W-1], w[WGT_W-2:0], r, c});
			if (!l)
				return;
			runs++;
			n = vertex_count;
			if (n < 1) n = 1;
			if (n > MAX_V) n = MAX_V;
			edge_keys.sort();
			for (int i = 0; i <= MAX_V; i++)
				parent[i] = i;
			total = 0;
			foreach (edge_keys[i]) begin
				if (picked.size() >= n - 1)
					break;
				k = edge_keys[i];
				if (k[IDX_W-1:0] > n)
					continue;
				ru = k[2*IDX_W-1:IDX_W];
				rv = k[IDX_W-1:0];
				for (steps = 0; steps <= MAX_V && parent[ru] != ru; steps++)
					ru = parent[ru];
				for (steps = 0; steps <= MAX_V && parent[rv] != rv; steps++)
					rv = parent[rv];
				if (ru == rv)
					continue;
				parent[rv] = ru;
				picked.push_back(k);
				total += int'(k[KEY_W-1:2*IDX_W]) - 32768;
			end
			if (picked.size() != n - 1) begin
				res = '0;
				res.lastr = 1'b1;
				tree_q.push_back(res);
			end else if (n == 1) begin
				res = '0;
				res.span = 1'b1;
				res.lastr = 1'b1;
				tree_q.push_back(res);
			end else begin
				foreach (picked[i]) begin
					res.u = picked[i][2*IDX_W-1:IDX_W];
					res.v = picked[i][IDX_W-1:0];
					res.valid = 1'b1;
					res.total = TOT_W'(total);
					res.span = 1'b1;
					res.lastr = (i == picked.size() - 1);
					tree_q.push_back(res);
				end
			end
			edge_keys.delete();
		endfunction

		function void check_result(tree_result_t got);
			tree_result_t want;
			if (tree_q.size() == 0) begin
				$error("result with nothing expected: u=%0d v=%0d", got.u, got.v);
				errors++;
				return;
			end
			want = tree_q.pop_front();
			checked++;
			if (got.u !== want.u) begin
				$error("edge_u: expected %0d, got %0d", want.u, got.u);
				errors++;
			end
			if (got.v !== want.v) begin
				$error("edge_v: expected %0d, got %0d", want.v, got.v);
				errors++;
			end
			if (got.valid !== want.valid) begin
				$error("edge_valid: expected %0d, got %0d", want.valid, got.valid);
				errors++;
			end
			if (got.total !== want.total) begin
				$error("total_weight: expected %0d, got %0d", want.total, got.total);
				errors++;
			end
			if (got.span !== want.span) begin
				$error("spanning: expected %0d, got %0d", want.span, got.span);
				errors++;
			end
			if (got.lastr !== want.lastr) begin
				$error("last_result: expected %0d, got %0d", want.lastr, got.lastr);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    wr_en = 1'b0;
	logic [IDX_W-1:0]        wr_data = '0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [IDX_W-1:0]        row = '0;
	logic [IDX_W-1:0]        col = '0;
	logic signed [WGT_W-1:0] weight = '0;
	logic                    last = 1'b0;
	logic                    result_valid;
	logic [IDX_W-1:0]        edge_u;
	logic [IDX_W-1:0]        edge_v;
	logic                    edge_valid;
	logic signed [TOT_W-1:0] total_weight;
	logic                    spanning;
	logic                    last_result;

	mst_scoreboard sb = new();
	int            stall_cycles = 0;
	int            entries_sent = 0;
	bit            gaps_on = 1'b1;

	kruskal_minimum_spanning_tree dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.start(start), .busy(busy), .row(row), .col(col), .weight(weight),
		.last(last), .result_valid(result_valid), .edge_u(edge_u),
		.edge_v(edge_v), .edge_valid(edge_valid), .total_weight(total_weight),
		.spanning(spanning), .last_result(last_result)
	);

	always #5 clk = ~clk;

	// result checking and stall watchdog
	always @(posedge clk) begin
		if (result_valid)
			sb.check_result('{edge_u, edge_v, edge_valid, total_weight, spanning,
				last_result});
		if (result_valid || (start && !busy) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_entry(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
	                          logic signed [WGT_W-1:0] w, logic l);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start  <= 1'b1;
		row    <= r;
		col    <= c;
		weight <= w;
		last   <= l;
		do @(posedge clk); while (busy);
		sb.note_entry(r, c, w, l);
		entries_sent++;
	endtask

	// idle the sender until the run is out, then let the block settle
	task automatic drain();
		start <= 1'b0;
		while (sb.tree_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_vertex_count(logic [IDX_W-1:0] n);
		wr_en   <= 1'b1;
		wr_data <= n;
		@(posedge clk);
		wr_en   <= 1'b0;
		sb.vertex_count = n;
	endtask

	function automatic logic signed [WGT_W-1:0] rand_weight(bit allow_zero);
		logic signed [WGT_W-1:0] w;
		case ($urandom_range(0, 4))
			0: w = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
			1: w = WGT_W'($urandom_range(1, 20));
			default: w = WGT_W'($urandom);
		endcase
		if (w == 0 && !allow_zero)
			w = 16'sd1;
		return w;
	endfunction

	initial begin
		int n, len, a, b;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset vertex count, disconnected graph with off-matrix and zero entries
		send_entry(1, 2, -16'sd32768, 0);
		send_entry(0, 5, 7, 0);
		send_entry(3, 3, 9, 0);
		send_entry(5, 4, 9, 0);
		send_entry(1, 63, 4, 0);
		send_entry(2, 7, 0, 0);
		send_entry(1, 2, -16'sd32768, 0);
		send_entry(31, 32, 16'sd32767, 1);
		drain();

		// zero vertex count behaves as a single vertex
		set_vertex_count(0);
		send_entry(1, 2, 100, 1);
		drain();
		set_vertex_count(1);
		send_entry(2, 3, -5, 1);
		drain();

		// three vertices, an edge past the vertex count is skipped
		set_vertex_count(3);
		send_entry(1, 2, 16'sd32767, 0);
		send_entry(2, 3, -16'sd32768, 0);
		send_entry(1, 4, -16'sd32000, 0);
		send_entry(1, 3, 16'sd32767, 0);
		send_entry(2, 3, -1, 1);
		drain();

		// over-range count clamps to the maximum: full chain
		set_vertex_count(63);
		for (int i = 1; i < MAX_V; i++)
			send_entry(IDX_W'(i), IDX_W'(i + 1), rand_weight(0), i == MAX_V - 1);
		drain();

		// random graphs, mostly well formed edges among the active vertices
		while (entries_sent < 160) begin
			if (entries_sent > 120)
				gaps_on = 1'b0;
			case ($urandom_range(0, 9))
				0: n = $urandom_range(0, 63);
				1, 2: n = $urandom_range(9, 32);
				default: n = $urandom_range(2, 8);
			endcase
			set_vertex_count(IDX_W'(n));
			if (n < 2) n = 2;
			if (n > MAX_V) n = MAX_V;
			len = $urandom_range(3, 25);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					send_entry(IDX_W'($urandom), IDX_W'($urandom), rand_weight(1),
						i == len - 1);
				end else begin
					a = $urandom_range(1, n - 1);
					b = $urandom_range(a + 1, n);
					send_entry(IDX_W'(a), IDX_W'(b), rand_weight(0), i == len - 1);
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d runs and %0d results, incl. disconnected, single vertex,",
			sb.runs, sb.checked);
		$display("skipped columns, clamped vertex counts and random graphs up to 32 vertices");
		if (sb.errors == 0 && sb.tree_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.tree_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
